// File: rtl/lgbps_pkg.sv
// Shared types, constants and helpers for the light gate break and phase sweep block.
package lgbps_pkg;

    localparam int CHANNELS_DEF   = 7;
    localparam int SWEEP_STEP_DEF = 30;
    localparam int SWEEP_END_DEF  = 8092;

    localparam int NUM_SAMPLES = 7;
    localparam int SAMPLE_W    = 12;
    localparam int CHAN_W      = 3;
    localparam int POS_W       = 14;
    localparam int OFFSET_W    = 13;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 12;

    localparam logic [SAMPLE_W-1:0]    LIMIT_RESET = 12'd1000;
    localparam logic [NUM_SAMPLES-1:0] MASK_RESET  = 7'd119;
    localparam logic [OFFSET_W-1:0]    OFFSET_MAX  = 13'd8191;

    // command codes
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_CH0   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_MASK = 4'd7;

    typedef logic [SAMPLE_W-1:0] t_sample;

    typedef struct packed {
        logic                command;
        t_sample             sample_0;
        t_sample             sample_1;
        t_sample             sample_2;
        t_sample             sample_3;
        t_sample             sample_4;
        t_sample             sample_5;
        t_sample             sample_6;
        logic [CHAN_W-1:0]   start_channel;
    } t_in_item;

    typedef struct packed {
        logic [NUM_SAMPLES-1:0] break_bits;
        logic                   any_broken;
        logic                   break_event;
        logic                   phase_valid;
        logic [CHAN_W-1:0]      phase_channel;
        logic [OFFSET_W-1:0]    phase_offset;
        logic                   channel_done;
        t_sample                peak_value;
        logic                   search_done;
        logic                   searching;
    } t_out_item;

    // sweep unit result toward the top level
    typedef struct packed {
        logic                phase_valid;
        logic [CHAN_W-1:0]   phase_channel;
        logic [OFFSET_W-1:0] phase_offset;
        logic                channel_done;
        t_sample             peak_value;
        logic                search_done;
        logic                searching;
    } t_sweep_res;

    function automatic logic [OFFSET_W-1:0] sat_offset(input logic [POS_W-1:0] pos);
        return (pos > POS_W'(OFFSET_MAX)) ? OFFSET_MAX : pos[OFFSET_W-1:0];
    endfunction

endpackage

// File: rtl/lgbps_sweep.sv
// Phase search sequencer: sweep position, peak tracking and channel advance.
module lgbps_sweep
    import lgbps_pkg::*;
#(
    parameter int NCH        = CHANNELS_DEF,
    parameter int SWEEP_STEP = SWEEP_STEP_DEF,
    parameter int SWEEP_END  = SWEEP_END_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_tick,
    input  logic              i_start,
    input  logic [CHAN_W-1:0] i_start_channel,
    input  t_sample           i_sample,
    output logic              o_active,
    output logic [CHAN_W-1:0] o_chan,
    output t_sweep_res        o_res
);

    localparam logic [CHAN_W:0]   NCH_V    = (CHAN_W+1)'(NCH);
    localparam logic [CHAN_W-1:0] LAST_CH  = CHAN_W'(NCH - 1);
    localparam logic [POS_W-1:0]  STEP_V   = POS_W'(SWEEP_STEP);
    localparam logic [POS_W-1:0]  END_V    = POS_W'(SWEEP_END);

    logic              r_on;
    logic [CHAN_W-1:0] r_chan;
    logic [POS_W-1:0]  r_pos;
    t_sample           r_best_sample;
    logic [POS_W-1:0]  r_best_pos;

    logic              n_on;
    logic [CHAN_W-1:0] n_chan;
    logic [POS_W-1:0]  n_pos;
    t_sample           n_best_sample;
    logic [POS_W-1:0]  n_best_pos;

    logic             start_ok;
    logic             higher;
    logic             end_hit;
    logic             last_ch;
    t_sample          peak;
    logic [POS_W-1:0] peak_pos;

    assign start_ok = i_start && ({1'b0, i_start_channel} < NCH_V);
    assign higher   = i_sample > r_best_sample;
    assign peak     = higher ? i_sample : r_best_sample;
    assign peak_pos = higher ? r_pos : r_best_pos;
    assign end_hit  = r_pos >= END_V;
    assign last_ch  = r_chan == LAST_CH;

    always_comb begin
        n_on          = r_on;
        n_chan        = r_chan;
        n_pos         = r_pos;
        n_best_sample = r_best_sample;
        n_best_pos    = r_best_pos;
        o_res         = '0;
        if (start_ok) begin
            n_on          = 1'b1;
            n_chan        = i_start_channel;
            n_pos         = '0;
            n_best_sample = '0;
        end else if (i_tick && r_on) begin
            n_best_sample       = peak;
            n_best_pos          = peak_pos;
            n_pos               = r_pos + STEP_V;
            o_res.phase_valid   = 1'b1;
            o_res.phase_channel = r_chan;
            o_res.phase_offset  = sat_offset(r_pos);
            if (end_hit) begin
                o_res.phase_offset = sat_offset(peak_pos);
                o_res.channel_done = 1'b1;
                o_res.peak_value   = peak;
                if (last_ch) begin
                    n_on               = 1'b0;
                    o_res.search_done  = 1'b1;
                end else begin
                    // next channel restarts one step in
                    n_chan        = r_chan + 1'b1;
                    n_pos         = STEP_V;
                    n_best_sample = '0;
                end
            end
        end
        o_res.searching = n_on;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on          <= 1'b0;
            r_chan        <= '0;
            r_pos         <= '0;
            r_best_sample <= '0;
            r_best_pos    <= '0;
        end else begin
            r_on          <= n_on;
            r_chan        <= n_chan;
            r_pos         <= n_pos;
            r_best_sample <= n_best_sample;
            r_best_pos    <= n_best_pos;
        end
    end

    assign o_active = r_on;
    assign o_chan   = r_chan;

endmodule

// File: rtl/light_gate_break_and_phase_sweep.sv
// Light gate break detector with receive phase search, top level.
//
// Input channel (i_in_valid / o_in_stall, payload i_in_item): one transaction is
// either a sampling tick carrying seven 12-bit receiver samples or a command
// to start a phase search at start_channel. Every transaction yields exactly
// one result transaction on the output channel (o_out_valid / i_out_stall,
// payload o_out_item).
// Each result is registered at accept, into the output or the skid register.
// Throughput: one transaction per cycle unless o_in_stall; all per-item work
// is one pass of compare and sweep logic up to the output register.
// When the receiver stalls, the result holds in the output register and one
// more transaction is taken into a skid register; o_in_stall rises only while
// the skid register is full, and is a pure register output.
// Configuration (i_cfg_valid / o_cfg_ready, index and data): indexes 0..6 set
// the per-channel break limits, index 7 the enable mask, others are dropped.
// The port is always ready; write only while the block is idle.
// Reset (synchronous, active low): limits 1000, enable mask 119, all sample,
// break and search state cleared, both result registers empty.
module light_gate_break_and_phase_sweep
    import lgbps_pkg::*;
#(
    parameter int CHANNELS   = CHANNELS_DEF,
    parameter int SWEEP_STEP = SWEEP_STEP_DEF,
    parameter int SWEEP_END  = SWEEP_END_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // only the first seven channels exist in hardware
    localparam int NCH = (CHANNELS < NUM_SAMPLES) ? CHANNELS : NUM_SAMPLES;

    // configuration registers
    t_sample                r_limit [NUM_SAMPLES];
    logic [NUM_SAMPLES-1:0] r_mask;

    // per-channel sample and break state
    t_sample                r_last [NUM_SAMPLES];
    logic [NUM_SAMPLES-1:0] r_break;
    logic                   r_prev_any;

    t_sample                n_last [NUM_SAMPLES];
    logic [NUM_SAMPLES-1:0] n_break;

    // output register and skid
    t_out_item r_out;
    logic      r_out_v;
    t_out_item r_skid;
    logic      r_skid_v;

    t_sample     samples [NUM_SAMPLES];
    logic        acc;
    logic        tick;
    logic        start;
    logic        any;
    logic        sweep_active;
    logic [CHAN_W-1:0] sweep_chan;
    t_sample     sweep_sample;
    t_sweep_res  sweep_res;
    t_out_item   res;

    assign acc   = i_in_valid && !o_in_stall;
    assign tick  = acc && (i_in_item.command == CMD_TICK);
    assign start = acc && (i_in_item.command == CMD_START);

    assign samples[0] = i_in_item.sample_0;
    assign samples[1] = i_in_item.sample_1;
    assign samples[2] = i_in_item.sample_2;
    assign samples[3] = i_in_item.sample_3;
    assign samples[4] = i_in_item.sample_4;
    assign samples[5] = i_in_item.sample_5;
    assign samples[6] = i_in_item.sample_6;

    // sample and break update: enabled channels take the new sample on a tick
    always_comb begin
        for (int i = 0; i < NUM_SAMPLES; i++) begin
            n_last[i]  = r_last[i];
            n_break[i] = r_break[i];
            if (tick && (i < NCH) && r_mask[i]) begin
                n_last[i]  = samples[i];
                n_break[i] = samples[i] < r_limit[i];
            end
        end
    end

    // any_broken counts only enabled channels' break bits
    assign any = |(n_break & r_mask);

    // the sweep looks at the searched channel's stored sample after this tick
    always_comb begin
        sweep_sample = n_last[0];
        for (int i = 0; i < NUM_SAMPLES; i++) begin
            if (sweep_chan == CHAN_W'(i)) begin
                sweep_sample = n_last[i];
            end
        end
    end

    lgbps_sweep #(
        .NCH        (NCH),
        .SWEEP_STEP (SWEEP_STEP),
        .SWEEP_END  (SWEEP_END)
    ) u_sweep (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_tick          (tick),
        .i_start         (start),
        .i_start_channel (i_in_item.start_channel),
        .i_sample        (sweep_sample),
        .o_active        (sweep_active),
        .o_chan          (sweep_chan),
        .o_res           (sweep_res)
    );

    // result assembly; break_event only on ticks outside a search
    always_comb begin
        res               = '0;
        res.break_bits    = n_break;
        res.any_broken    = any;
        res.break_event   = tick && !sweep_active && (any != r_prev_any);
        res.phase_valid   = sweep_res.phase_valid;
        res.phase_channel = sweep_res.phase_channel;
        res.phase_offset  = sweep_res.phase_offset;
        res.channel_done  = sweep_res.channel_done;
        res.peak_value    = sweep_res.peak_value;
        res.search_done   = sweep_res.search_done;
        res.searching     = sweep_res.searching;
    end

    // state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_break    <= '0;
            r_prev_any <= 1'b0;
            r_mask     <= MASK_RESET;
            for (int i = 0; i < NUM_SAMPLES; i++) begin
                r_last[i]  <= '0;
                r_limit[i] <= LIMIT_RESET;
            end
        end else begin
            r_break <= n_break;
            for (int i = 0; i < NUM_SAMPLES; i++) begin
                r_last[i] <= n_last[i];
            end
            if (tick && !sweep_active) begin
                r_prev_any <= any;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index < CFG_ENABLE_MASK) begin
                    r_limit[i_cfg_index[CHAN_W-1:0]] <= i_cfg_data[SAMPLE_W-1:0];
                end else if (i_cfg_index == CFG_ENABLE_MASK) begin
                    r_mask <= i_cfg_data[NUM_SAMPLES-1:0];
                end
            end
        end
    end

    // output register with one-entry skid; input stalls only when skid is full
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (!r_out_v || !i_out_stall) begin
                if (r_skid_v) begin
                    r_out    <= r_skid;
                    r_out_v  <= 1'b1;
                    r_skid_v <= 1'b0;
                end else begin
                    r_out_v <= acc;
                    if (acc) begin
                        r_out <= res;
                    end
                end
            end else if (acc) begin
                r_skid   <= res;
                r_skid_v <= 1'b1;
            end
        end
    end

    assign o_in_stall  = r_skid_v;
    assign o_out_valid = r_out_v;
    assign o_out_item  = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

// File: verif/beam_result_checker.sv
// Result checker for the light gate break and phase sweep block: predicts and compares.
module beam_result_checker
    import lgbps_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  t_in_item              i_in_item,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  t_out_item             i_out_item,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_REPORTS = 10;

    // register copy
    t_sample                gate_limit [NUM_SAMPLES];
    logic [NUM_SAMPLES-1:0] live_mask;

    // gate and sweep state
    t_sample                held_sample [NUM_SAMPLES];
    logic [NUM_SAMPLES-1:0] beam_broken;
    logic                   last_any;
    logic                   sweep_on;
    logic [CHAN_W-1:0]      sweep_chan;
    logic [POS_W-1:0]       sweep_pos;
    t_sample                peak_sample;
    logic [POS_W-1:0]       peak_pos;

    t_out_item due_results [$];

    function automatic logic [OFFSET_W-1:0] clip_offset(input logic [POS_W-1:0] p);
        return (p > POS_W'(OFFSET_MAX)) ? OFFSET_MAX : p[OFFSET_W-1:0];
    endfunction

    function automatic t_out_item gate_and_sweep(input t_in_item it);
        t_out_item         r;
        t_sample           smp [NUM_SAMPLES];
        logic [CHAN_W-1:0] ch;
        int                i;
        r      = '0;
        smp[0] = it.sample_0;
        smp[1] = it.sample_1;
        smp[2] = it.sample_2;
        smp[3] = it.sample_3;
        smp[4] = it.sample_4;
        smp[5] = it.sample_5;
        smp[6] = it.sample_6;
        if (it.command == CMD_START) begin
            if (it.start_channel < NUM_SAMPLES) begin
                sweep_on    = 1'b1;
                sweep_chan  = it.start_channel;
                sweep_pos   = '0;
                peak_sample = '0;
            end
        end else begin
            for (i = 0; i < NUM_SAMPLES; i++) begin
                if (live_mask[i]) begin
                    held_sample[i] = smp[i];
                    beam_broken[i] = smp[i] < gate_limit[i];
                end
            end
        end
        r.break_bits = beam_broken;
        r.any_broken = |(beam_broken & live_mask);
        if (it.command == CMD_TICK) begin
            if (sweep_on) begin
                ch = (sweep_chan >= NUM_SAMPLES) ? CHAN_W'(NUM_SAMPLES - 1) : sweep_chan;
                r.phase_valid   = 1'b1;
                r.phase_channel = ch;
                r.phase_offset  = clip_offset(sweep_pos);
                // sweep reads the held sample, even for a masked channel
                if (held_sample[ch] > peak_sample) begin
                    peak_sample = held_sample[ch];
                    peak_pos    = sweep_pos;
                end
                if (sweep_pos >= SWEEP_END_DEF) begin
                    r.phase_offset = clip_offset(peak_pos);
                    r.channel_done = 1'b1;
                    r.peak_value   = peak_sample;
                    if (ch == NUM_SAMPLES - 1) begin
                        sweep_on      = 1'b0;
                        r.search_done = 1'b1;
                    end else begin
                        sweep_chan  = ch + 1'b1;
                        sweep_pos   = '0;
                        peak_sample = '0;
                    end
                end
                sweep_pos = POS_W'(sweep_pos + SWEEP_STEP_DEF);
            end else begin
                r.break_event = r.any_broken != last_any;
                last_any      = r.any_broken;
            end
        end
        r.searching = sweep_on;
        return r;
    endfunction

    function automatic string field_diff(input string name, input logic [15:0] want,
                                         input logic [15:0] got);
        return (want !== got) ? $sformatf(" %s exp=%0h got=%0h", name, want, got) : "";
    endfunction

    always @(posedge i_clk) begin : watch
        t_out_item want;
        string     diffs;
        int        i;
        if (!i_rst_n) begin
            for (i = 0; i < NUM_SAMPLES; i++) begin
                gate_limit[i]  = LIMIT_RESET;
                held_sample[i] = '0;
            end
            live_mask    = MASK_RESET;
            beam_broken  = '0;
            last_any     = 1'b0;
            sweep_on     = 1'b0;
            sweep_chan   = '0;
            sweep_pos    = '0;
            peak_sample  = '0;
            peak_pos     = '0;
            o_fail_count = 0;
            due_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index < CFG_LIMIT_CH0 + NUM_SAMPLES)
                    gate_limit[i_cfg_index - CFG_LIMIT_CH0] = i_cfg_data;
                else if (i_cfg_index == CFG_ENABLE_MASK)
                    live_mask = i_cfg_data[NUM_SAMPLES-1:0];
            end
            if (i_in_valid && !i_in_stall)
                due_results.push_back(gate_and_sweep(i_in_item));
            if (i_out_valid && !i_out_stall) begin
                if (due_results.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= MAX_REPORTS)
                        $display("%0t: result transaction with none expected: %h",
                                 $realtime, i_out_item);
                end else begin
                    want  = due_results.pop_front();
                    diffs = {field_diff("break_bits", want.break_bits, i_out_item.break_bits),
                             field_diff("any_broken", want.any_broken, i_out_item.any_broken),
                             field_diff("break_event", want.break_event,
                                        i_out_item.break_event),
                             field_diff("phase_valid", want.phase_valid,
                                        i_out_item.phase_valid),
                             field_diff("phase_channel", want.phase_channel,
                                        i_out_item.phase_channel),
                             field_diff("phase_offset", want.phase_offset,
                                        i_out_item.phase_offset),
                             field_diff("channel_done", want.channel_done,
                                        i_out_item.channel_done),
                             field_diff("peak_value", want.peak_value, i_out_item.peak_value),
                             field_diff("search_done", want.search_done,
                                        i_out_item.search_done),
                             field_diff("searching", want.searching, i_out_item.searching)};
                    if (diffs != "") begin
                        o_fail_count++;
                        if (o_fail_count <= MAX_REPORTS)
                            $display("%0t: result mismatch:%s", $realtime, diffs);
                    end
                end
            end
        end
        o_pending = due_results.size();
    end

endmodule

// File: verif/light_gate_break_and_phase_sweep_test.sv
// Stimulus and verdict for the light gate break and phase sweep block.
module light_gate_break_and_phase_sweep_test;
    import lgbps_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Run length and traffic shape.
    localparam int TOTAL_ITEMS = 1925;    // directed part plus about 1900 random
    localparam int IDLE_PCT    = 29;      // chance per cycle that a side idles
    localparam int HOLD_CYCLES = 40;      // receiver hold-off for the fill test
    localparam int CYCLE_LIMIT = 200000;  // watchdog, far above a clean run

    // First unused register index; everything from here up is dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_FIRST = CFG_ENABLE_MASK + 1'b1;
    // A start naming this channel (one above the last) must be ignored.
    localparam logic [CHAN_W-1:0]    CHAN_BEYOND      = CHAN_W'(NUM_SAMPLES);

    // How a tick fills its seven samples.
    typedef enum int {
        SMP_RANDOM,   // full range
        SMP_EDGES,    // 0, 4095 and limit-1 / limit / limit+1
        SMP_ZERO,     // nothing ever beats a zero peak
        SMP_FLAT,     // one level everywhere: peak ties
        SMP_NEAR      // within a few codes of the limit
    } t_sample_style;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in_item              i_in_item;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_out_item             o_out_item;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int      fail_count;
    int      pending;
    int      cycles;
    int      sent;
    int      idle_pct;
    int      holds_asked;
    int      holds_done;
    t_sample limit_copy [NUM_SAMPLES];   // what the block's limits are now
    t_sample flat_level;

    light_gate_break_and_phase_sweep dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // The checker sees every transaction on all three channels and keeps its
    // own model of the gate and sweep state.
    beam_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_item    (i_in_item),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_item   (o_out_item),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake ends the run here.
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    // Result side. Normally stalls at random; when the stimulus asks for a
    // hold-off it keeps stall high for the whole hold-off, timed right here, so
    // the output and skid registers fill and the block stalls its input.
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holds_done < holds_asked) begin
                i_out_stall = 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                holds_done++;
            end else begin
                i_out_stall = ($urandom_range(99) < idle_pct);
            end
        end
    end

    function automatic t_sample pick_sample(input t_sample_style style, input int ch);
        case (style)
            SMP_EDGES:
                case ($urandom_range(4))
                    0:       return '0;
                    1:       return '1;
                    2:       return limit_copy[ch] - 1'b1;
                    3:       return limit_copy[ch];
                    default: return limit_copy[ch] + 1'b1;
                endcase
            SMP_ZERO: return '0;
            SMP_FLAT: return flat_level;
            SMP_NEAR: return limit_copy[ch] + t_sample'($urandom_range(16)) - t_sample'(8);
            default:  return t_sample'($urandom_range(4095));
        endcase
    endfunction

    // start_channel is don't-care on a tick, so it is randomized there.
    function automatic t_in_item make_tick(input t_sample_style style);
        t_in_item it;
        it.command       = CMD_TICK;
        it.sample_0      = pick_sample(style, 0);
        it.sample_1      = pick_sample(style, 1);
        it.sample_2      = pick_sample(style, 2);
        it.sample_3      = pick_sample(style, 3);
        it.sample_4      = pick_sample(style, 4);
        it.sample_5      = pick_sample(style, 5);
        it.sample_6      = pick_sample(style, 6);
        it.start_channel = CHAN_W'($urandom);
        return it;
    endfunction

    // Samples are don't-care on a start, so they carry junk.
    function automatic t_in_item make_start(input logic [CHAN_W-1:0] ch);
        t_in_item it;
        it               = make_tick(SMP_RANDOM);
        it.command       = CMD_START;
        it.start_channel = ch;
        return it;
    endfunction

    function automatic t_in_item make_level(input t_sample level);
        flat_level = level;
        return make_tick(SMP_FLAT);
    endfunction

    // Ticks from a start at channel ch until search_done. The first channel
    // sweeps from position 0, every later one from SWEEP_STEP: one tick less.
    function automatic int sweep_ticks(input int ch);
        int first;
        first = (SWEEP_END_DEF + SWEEP_STEP_DEF - 1) / SWEEP_STEP_DEF + 1;
        return first + (NUM_SAMPLES - 1 - ch) * (first - 1);
    endfunction

    // One input transaction. Called and returns at a falling edge; valid
    // stays high on return so the next call can go back to back.
    task automatic offer(input t_in_item it);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_item  = it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
        sent++;
    endtask

    // Leaves cfg_valid high; the caller drops it after its last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        if (idx < CFG_LIMIT_CH0 + NUM_SAMPLES)
            limit_copy[idx - CFG_LIMIT_CH0] = data;
    endtask

    // Every result back; one result per item, so the block is idle after this.
    task automatic settle();
        i_in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic new_settings();
        logic [CFG_DATA_W-1:0] data;
        int                    i;
        settle();
        for (i = 0; i < NUM_SAMPLES; i++) begin
            case ($urandom_range(5))
                0:       data = '0;
                1:       data = '1;
                2:       data = LIMIT_RESET;
                default: data = CFG_DATA_W'($urandom_range(4095));
            endcase
            write_reg(CFG_IDX_W'(CFG_LIMIT_CH0 + i), data);
        end
        // upper data bits are junk for the mask register
        data = CFG_DATA_W'($urandom_range(4095));
        case ($urandom_range(9))
            0:       data[NUM_SAMPLES-1:0] = '0;
            1, 2:    data[NUM_SAMPLES-1:0] = '1;
            default: ;
        endcase
        write_reg(CFG_ENABLE_MASK, data);
        if ($urandom_range(3) == 0)
            write_reg(CFG_IDX_W'($urandom_range(CFG_UNUSED_FIRST, (1 << CFG_IDX_W) - 1)),
                      CFG_DATA_W'($urandom));
        i_cfg_valid = 1'b0;
    endtask

    // Start at ch, then n ticks. A few ignored starts are mixed in as noise.
    task automatic run_search(input logic [CHAN_W-1:0] ch, input int n,
                              input t_sample_style style);
        offer(make_start(ch));
        repeat (n) begin
            if ($urandom_range(49) == 0)
                offer(make_start(CHAN_BEYOND));
            offer(make_tick(style));
        end
    endtask

    initial begin : stimulus
        t_sample_style style;
        logic [CHAN_W-1:0] ch;
        int i;
        int n;

        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        sent        = 0;
        idle_pct    = IDLE_PCT;
        holds_asked = 0;
        holds_done  = 0;
        flat_level  = '0;
        for (i = 0; i < NUM_SAMPLES; i++)
            limit_copy[i] = LIMIT_RESET;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // ---- Directed part, reset settings (limit 1000, channel 3 masked) ----
        offer(make_level('1));               // nothing broken, no event
        offer(make_level('0));               // all enabled broken: event
        offer(make_level(12'd999));          // one below the limit: still broken
        offer(make_level(12'd1000));         // at the limit: clear, event again
        offer(make_start(CHAN_BEYOND));      // ignored start
        offer(make_start(CHAN_W'(NUM_SAMPLES - 1)));
        repeat (3) offer(make_tick(SMP_EDGES));
        offer(make_start(CHAN_W'(3)));       // restart mid sweep
        repeat (2) offer(make_tick(SMP_EDGES));
        offer(make_start(CHAN_BEYOND));      // ignored while searching
        offer(make_tick(SMP_RANDOM));

        // Limit extremes: 0 can never break, 4095 breaks on all but 4095.
        settle();
        for (i = 0; i < NUM_SAMPLES; i++)
            write_reg(CFG_IDX_W'(CFG_LIMIT_CH0 + i), (i < 4) ? '0 : '1);
        write_reg(CFG_ENABLE_MASK, '1);
        write_reg('1, '1);                   // top unused index, dropped
        i_cfg_valid = 1'b0;
        offer(make_level('0));
        offer(make_level('1));
        offer(make_tick(SMP_EDGES));

        // All channels masked: samples are held, break bits frozen.
        settle();
        write_reg(CFG_ENABLE_MASK, '0);
        i_cfg_valid = 1'b0;
        repeat (2) offer(make_tick(SMP_RANDOM));

        // ---- Random part ----
        // One whole sweep of the last channel with neither side idling.
        new_settings();
        idle_pct = 0;
        run_search(CHAN_W'(NUM_SAMPLES - 1), sweep_ticks(NUM_SAMPLES - 1) + 2, SMP_RANDOM);

        // Fill test: receiver holds off while the sender keeps offering.
        holds_asked++;
        repeat (60) offer(make_tick(SMP_RANDOM));
        idle_pct = IDLE_PCT;

        // Two channels: covers the hand-over to the next channel.
        new_settings();
        run_search(CHAN_W'(NUM_SAMPLES - 2), sweep_ticks(NUM_SAMPLES - 2) + 1, SMP_RANDOM);

        // All-zero sweep: peak never moves, best position is the stale one.
        run_search(CHAN_W'(NUM_SAMPLES - 1), sweep_ticks(NUM_SAMPLES - 1), SMP_ZERO);

        while (sent < TOTAL_ITEMS) begin
            if ($urandom_range(3) == 0)
                new_settings();
            flat_level = t_sample'($urandom_range(4095));
            style      = t_sample_style'($urandom_range(SMP_NEAR));
            idle_pct   = ($urandom_range(7) == 0) ? 0 : IDLE_PCT;
            if ($urandom_range(2) == 0) begin
                // plain ticks, with ignored and the odd real start
                n = $urandom_range(20, 60);
                if (n > TOTAL_ITEMS - sent)
                    n = TOTAL_ITEMS - sent;
                repeat (n) begin
                    case ($urandom_range(39))
                        0:       offer(make_start(CHAN_BEYOND));
                        1:       offer(make_start(CHAN_W'($urandom_range(NUM_SAMPLES - 1))));
                        default: offer(make_tick(style));
                    endcase
                end
            end else begin
                // mostly sweeps run to search_done, the rest cut short
                case ($urandom_range(9))
                    0, 1, 2, 3, 4: ch = CHAN_W'(NUM_SAMPLES - 1);
                    5, 6:          ch = CHAN_W'(NUM_SAMPLES - 2);
                    default:       ch = CHAN_W'($urandom_range(NUM_SAMPLES - 3));
                endcase
                if (ch >= NUM_SAMPLES - 2)
                    n = sweep_ticks(ch) + $urandom_range(3);
                else
                    n = $urandom_range(20, 300);
                // keep the total near the target
                if (n > TOTAL_ITEMS - sent)
                    n = TOTAL_ITEMS - sent;
                run_search(ch, n, style);
            end
        end

        // Drain, give the pipeline a few more cycles, then the verdict.
        idle_pct = IDLE_PCT;
        settle();
        repeat (4) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: sim.f
rtl/lgbps_pkg.sv
rtl/lgbps_sweep.sv
rtl/light_gate_break_and_phase_sweep.sv
verif/beam_result_checker.sv
verif/light_gate_break_and_phase_sweep_test.sv
